FILE: design/cfr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfr_pkg
// Shared constants and types of the controller frame receiver.
// ----------------------------------------------------------------------------
package cfr_pkg;

  // Frame geometry: start, length, payload, checksum
  localparam int unsigned PAYLOAD_BYTES = 17;
  localparam int unsigned FRAME_BYTES   = PAYLOAD_BYTES + 3;
  localparam int unsigned FILL_W        = $clog2(FRAME_BYTES + 1);
  localparam int unsigned SUM_BYTES     = FRAME_BYTES - 1;

  localparam logic [7:0] PAYLOAD_LEN   = 8'(PAYLOAD_BYTES & 8'hFF);
  localparam logic [7:0] START_DEFAULT = 8'hAA;

  // Button positions in the button byte
  localparam int unsigned BTN_TRACKED = 5;
  localparam logic [BTN_TRACKED-1:0] BTN_CRAB_MASK = BTN_TRACKED'(1 << 0);
  localparam logic [BTN_TRACKED-1:0] BTN_TILT_MASK = BTN_TRACKED'(1 << 1);
  localparam logic [BTN_TRACKED-1:0] BTN_ALL_MASK  = BTN_TRACKED'((1 << 4) * 2 - 1);

  typedef logic [7:0] byte_t;

  typedef struct packed {
    logic [15:0]            joy1_vertical;
    logic [15:0]            joy1_horizontal;
    logic [15:0]            joy2_vertical;
    logic [15:0]            joy2_horizontal;
    logic [15:0]            knob_three;
    logic [15:0]            knob_four;
    logic [15:0]            knob_one;
    logic [15:0]            knob_two;
    logic [7:0]             button_bits;
    logic [BTN_TRACKED-1:0] button_rises;
    logic                   crab_mode;
    logic                   tilt_mode;
  } result_t;

endpackage

FILE: design/cfr_byte_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfr_byte_if
// Received-byte channel: valid/ready with one serial byte.
// ----------------------------------------------------------------------------
interface cfr_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

FILE: design/cfr_cfg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfr_cfg_if
// Configuration write channel for the start marker register.
// ----------------------------------------------------------------------------
interface cfr_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] start_marker;

  modport source (output valid, output start_marker, input ready);
  modport sink   (input valid, input start_marker, output ready);
endinterface

FILE: design/cfr_result_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfr_result_if
// Decoded frame channel: valid/ready with channels, buttons and mode flags.
// ----------------------------------------------------------------------------
interface cfr_result_if;
  logic        valid;
  logic        ready;
  logic [15:0] joy1_vertical;
  logic [15:0] joy1_horizontal;
  logic [15:0] joy2_vertical;
  logic [15:0] joy2_horizontal;
  logic [15:0] knob_three;
  logic [15:0] knob_four;
  logic [15:0] knob_one;
  logic [15:0] knob_two;
  logic [7:0]  button_bits;
  logic [4:0]  button_rises;
  logic        crab_mode;
  logic        tilt_mode;

  modport source (
    output valid, input ready,
    output joy1_vertical, output joy1_horizontal, output joy2_vertical,
    output joy2_horizontal, output knob_three, output knob_four,
    output knob_one, output knob_two, output button_bits,
    output button_rises, output crab_mode, output tilt_mode
  );
  modport sink (
    input valid, output ready,
    input joy1_vertical, input joy1_horizontal, input joy2_vertical,
    input joy2_horizontal, input knob_three, input knob_four,
    input knob_one, input knob_two, input button_bits,
    input button_rises, input crab_mode, input tilt_mode
  );
endinterface

FILE: design/cfr_window.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfr_window
// Sliding frame window with fill count and running checksum; flags a hit
// when the window after the new byte holds a complete valid frame.
// ----------------------------------------------------------------------------
module cfr_window (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                shift_i,
  input  cfr_pkg::byte_t      byte_i,
  input  cfr_pkg::byte_t      marker_i,
  output logic                hit_o,
  output cfr_pkg::byte_t      payload_o [cfr_pkg::PAYLOAD_BYTES]
);

  cfr_pkg::byte_t                 win_q [cfr_pkg::FRAME_BYTES];
  cfr_pkg::byte_t                 win_d [cfr_pkg::FRAME_BYTES];
  logic [cfr_pkg::FILL_W-1:0]     fill_q, fill_d;
  cfr_pkg::byte_t                 sum_q, sum_d;
  logic                           full_d;

  // Newest byte enters at the top, oldest falls out of slot 0
  always_comb begin
    for (int i = 0; i < cfr_pkg::FRAME_BYTES - 1; i++) begin
      win_d[i] = win_q[i+1];
    end
    win_d[cfr_pkg::FRAME_BYTES-1] = byte_i;
  end

  // Running sum of slots 0..FRAME_BYTES-2 follows the shift
  assign sum_d = sum_q - win_q[0] + win_q[cfr_pkg::FRAME_BYTES-1];

  // Fill saturates at a full frame
  assign full_d = (fill_q >= cfr_pkg::FILL_W'(cfr_pkg::FRAME_BYTES - 1));
  assign fill_d = full_d ? cfr_pkg::FILL_W'(cfr_pkg::FRAME_BYTES)
                         : fill_q + cfr_pkg::FILL_W'(1);

  // Frame check on the updated window
  assign hit_o = shift_i && full_d
              && (win_d[0] == marker_i)
              && (win_d[1] == cfr_pkg::PAYLOAD_LEN)
              && (sum_d == win_d[cfr_pkg::FRAME_BYTES-1]);

  always_comb begin
    for (int i = 0; i < cfr_pkg::PAYLOAD_BYTES; i++) begin
      payload_o[i] = win_d[i+2];
    end
  end

  // Window, sum and fill; a hit restarts the fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      sum_q  <= '0;
      for (int i = 0; i < cfr_pkg::FRAME_BYTES; i++) begin
        win_q[i] <= '0;
      end
    end else if (shift_i) begin
      fill_q <= hit_o ? '0 : fill_d;
      sum_q  <= sum_d;
      for (int i = 0; i < cfr_pkg::FRAME_BYTES; i++) begin
        win_q[i] <= win_d[i];
      end
    end
  end

  // A hit always restarts the fill
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    hit_o |=> (fill_q == '0))
    else $error("window fill not cleared after frame hit");

  // Fill never passes a full frame
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    shift_i && (fill_q == cfr_pkg::FILL_W'(cfr_pkg::FRAME_BYTES)) && !hit_o
    |=> (fill_q == cfr_pkg::FILL_W'(cfr_pkg::FRAME_BYTES)))
    else $error("window fill left saturation without a hit");

endmodule

FILE: design/cfr_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfr_decode
// Unpacks a valid frame's payload into channels and buttons, tracks button
// edges and the two toggled mode flags.
// ----------------------------------------------------------------------------
module cfr_decode (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             hit_i,
  input  cfr_pkg::byte_t   payload_i [cfr_pkg::PAYLOAD_BYTES],
  output cfr_pkg::result_t result_o
);

  cfr_pkg::byte_t                      last_q;
  logic                                crab_q, crab_d;
  logic                                tilt_q, tilt_d;
  cfr_pkg::byte_t                      cur;
  logic [cfr_pkg::BTN_TRACKED-1:0]     rises;

  // Button edges and mode toggles
  assign cur    = payload_i[cfr_pkg::PAYLOAD_BYTES-1];
  assign rises  = cur[cfr_pkg::BTN_TRACKED-1:0] & ~last_q[cfr_pkg::BTN_TRACKED-1:0]
                & cfr_pkg::BTN_ALL_MASK;
  assign crab_d = crab_q ^ (|(rises & cfr_pkg::BTN_CRAB_MASK));
  assign tilt_d = tilt_q ^ (|(rises & cfr_pkg::BTN_TILT_MASK));

  // Little-endian channel pairs
  always_comb begin
    result_o.joy1_vertical   = {payload_i[1],  payload_i[0]};
    result_o.joy1_horizontal = {payload_i[3],  payload_i[2]};
    result_o.joy2_vertical   = {payload_i[5],  payload_i[4]};
    result_o.joy2_horizontal = {payload_i[7],  payload_i[6]};
    result_o.knob_three      = {payload_i[9],  payload_i[8]};
    result_o.knob_four       = {payload_i[11], payload_i[10]};
    result_o.knob_one        = {payload_i[13], payload_i[12]};
    result_o.knob_two        = {payload_i[15], payload_i[14]};
    result_o.button_bits     = cur;
    result_o.button_rises    = rises;
    result_o.crab_mode       = crab_d;
    result_o.tilt_mode       = tilt_d;
  end

  // Button history and flags move only on a valid frame
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q <= '0;
      crab_q <= 1'b0;
      tilt_q <= 1'b0;
    end else if (hit_i) begin
      last_q <= cur;
      crab_q <= crab_d;
      tilt_q <= tilt_d;
    end
  end

  // Mode flags hold between frames
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !hit_i |=> ($stable(crab_q) && $stable(tilt_q) && $stable(last_q)))
    else $error("button state changed without a frame");

endmodule

FILE: design/controller_frame_receiver.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// controller_frame_receiver
// Frame sync and decode for a start/length/payload/sum8 controller stream.
//
// Accepts one received byte per clock and returns one decoded transaction
// for every valid frame found in the byte stream, once the frame's last
// byte has passed the input register and then the result register. The
// rate is one byte per cycle: the frame check uses a running 8-bit sum of
// the window, so each byte costs one subtract, one add and three byte
// compares. While a result waits at the output the block still takes a
// byte into its input register; it stalls only when both registers are
// full. The start marker resets to 0xAA and may be rewritten while idle.
// ----------------------------------------------------------------------------
module controller_frame_receiver (
  input  logic       clk_i,
  input  logic       rst_ni,
  cfr_cfg_if.sink    cfg_i,
  cfr_byte_if.sink   byte_i,
  cfr_result_if.source result_o
);

  logic              byte_vld_q;
  cfr_pkg::byte_t    byte_q;
  cfr_pkg::byte_t    marker_q;
  logic              out_vld_q;
  cfr_pkg::result_t  out_q;
  logic              advance;
  logic              hit;
  cfr_pkg::byte_t    payload [cfr_pkg::PAYLOAD_BYTES];
  cfr_pkg::result_t  result;

  // Configuration register, always writable
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      marker_q <= cfr_pkg::START_DEFAULT;
    end else if (cfg_i.valid) begin
      marker_q <= cfg_i.start_marker;
    end
  end

  // Byte stage moves on when the result register can take its outcome
  assign advance      = byte_vld_q && (!out_vld_q || result_o.ready);
  assign byte_i.ready = !byte_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_vld_q <= 1'b0;
    end else if (byte_i.ready) begin
      byte_vld_q <= byte_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (byte_i.valid && byte_i.ready) begin
      byte_q <= byte_i.rx_byte;
    end
  end

  cfr_window u_window (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .shift_i   (advance),
    .byte_i    (byte_q),
    .marker_i  (marker_q),
    .hit_o     (hit),
    .payload_o (payload)
  );

  cfr_decode u_decode (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .hit_i    (hit),
    .payload_i(payload),
    .result_o (result)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance && hit) begin
      out_vld_q <= 1'b1;
    end else if (result_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && hit) begin
      out_q <= result;
    end
  end

  assign result_o.valid           = out_vld_q;
  assign result_o.joy1_vertical   = out_q.joy1_vertical;
  assign result_o.joy1_horizontal = out_q.joy1_horizontal;
  assign result_o.joy2_vertical   = out_q.joy2_vertical;
  assign result_o.joy2_horizontal = out_q.joy2_horizontal;
  assign result_o.knob_three      = out_q.knob_three;
  assign result_o.knob_four       = out_q.knob_four;
  assign result_o.knob_one        = out_q.knob_one;
  assign result_o.knob_two        = out_q.knob_two;
  assign result_o.button_bits     = out_q.button_bits;
  assign result_o.button_rises    = out_q.button_rises;
  assign result_o.crab_mode       = out_q.crab_mode;
  assign result_o.tilt_mode       = out_q.tilt_mode;

  // A frame hit is never dropped
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && hit) |=> out_vld_q)
    else $error("frame hit did not load the result register");

  // Window never shifts while an unread result blocks the output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !result_o.ready) |-> !advance)
    else $error("byte processed while result stalled");

  // A held byte stays put until processed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (byte_vld_q && !advance) |=> (byte_vld_q && $stable(byte_q)))
    else $error("pending byte lost or changed");

endmodule
